// ===== sv/ecfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ecfs_pkg: shared types and constants for the escaped CRC frame sender
// Byte codes, status codes, the per-item burst descriptor and the CRC fold.
// ----------------------------------------------------------------------------
`default_nettype none

package ecfs_pkg;

  localparam int IN_DATA_W  = 40;  // frame_length, data_byte
  localparam int OUT_DATA_W = 16;  // out_byte, frame_done, status, zero fill
  localparam int BURST_LEN  = 5;   // most raw bytes one item produces

  localparam logic [16:0] CRC_GEN    = 17'h11021;
  localparam logic [7:0]  ESC_BYTE   = 8'h1b;
  localparam logic [7:0]  CTLC_BYTE  = 8'h03;
  localparam logic [7:0]  START_MARK = 8'h3a;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_LEN = 2'd1,
    STAT_NO_FRAME = 2'd2
  } status_t;

  // Raw (unescaped) bytes caused by one input item, oldest in slot 0
  typedef struct packed {
    logic [BURST_LEN-1:0][7:0] bytes;
    logic [2:0]                last_idx;   // number of bytes minus one
    logic                      byte_valid; // 0 for a status-only result
    logic                      done;       // last byte closes the frame
    status_t                   status;
  } burst_t;

  // CRC-16, generator 0x11021, message bits shifted in MSB first, no augmentation
  function automatic logic [15:0] crc_fold(logic [15:0] c, logic [7:0] b);
    logic [16:0] r;
    r = {1'b0, c};
    for (int i = 7; i >= 0; i--) begin
      r = {r[15:0], b[i]};
      if (r[16]) begin
        r = r ^ CRC_GEN;
      end
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/ecfs_build.sv =====
// ----------------------------------------------------------------------------
// ecfs_build: frame state and burst builder
// Holds CRC, byte count and frame-open flag; turns an item into raw bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ecfs_build
  import ecfs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic         mode,
  input  wire logic [31:0]  frame_length,
  input  wire logic [7:0]   data_byte,
  output burst_t            burst
);

  logic [15:0] crc_r, crc_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic        open_r, open_nxt;

  logic [15:0] crc_fold_val;
  logic [31:0] remaining_dec;

  assign crc_fold_val  = crc_fold(crc_r, data_byte);
  assign remaining_dec = remaining_r - 32'd1;

  always_comb begin
    crc_nxt       = crc_r;
    remaining_nxt = remaining_r;
    open_nxt      = open_r;

    burst            = '0;
    burst.byte_valid = 1'b1;
    burst.status     = STAT_OK;

    if (mode == MODE_HEADER) begin
      if (frame_length == 32'd0) begin
        burst.byte_valid = 1'b0;
        burst.status     = STAT_ZERO_LEN;
      end else begin
        burst.bytes[0] = START_MARK;
        burst.bytes[1] = frame_length[7:0];
        burst.bytes[2] = frame_length[15:8];
        burst.bytes[3] = frame_length[23:16];
        burst.bytes[4] = frame_length[31:24];
        burst.last_idx = 3'd4;
        crc_nxt        = 16'd0;
        remaining_nxt  = frame_length;
        open_nxt       = 1'b1;
      end
    end else if (!open_r) begin
      burst.byte_valid = 1'b0;
      burst.status     = STAT_NO_FRAME;
    end else begin
      burst.bytes[0] = data_byte;
      crc_nxt        = crc_fold_val;
      remaining_nxt  = remaining_dec;
      if (remaining_dec == 32'd0) begin
        // last counted byte: CRC follows, low byte first
        burst.bytes[1] = crc_fold_val[7:0];
        burst.bytes[2] = crc_fold_val[15:8];
        burst.last_idx = 3'd2;
        burst.done     = 1'b1;
        open_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      remaining_r <= '0;
      open_r      <= 1'b0;
    end else if (accept) begin
      crc_r       <= crc_nxt;
      remaining_r <= remaining_nxt;
      open_r      <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ecfs_emit.sv =====
// ----------------------------------------------------------------------------
// ecfs_emit: burst register, ESC insertion and output register
// Walks the held burst one line byte per cycle unless out_tready stalls, prefixing ESC/^C bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module ecfs_emit
  import ecfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire burst_t                burst,
  output logic                       can_load,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);

  burst_t                burst_r;
  logic                  burst_valid_r;
  logic                  esc_sent_r;

  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;
  logic                  out_done_r;
  logic                  out_bvalid_r;
  status_t               out_status_r;

  logic                  fire;
  logic                  step;
  logic [7:0]            cur;
  logic                  is_esc;
  logic                  is_last;
  logic                  finishing;

  assign fire      = !out_valid_r || out_tready;
  assign step      = burst_valid_r && fire;
  assign cur       = burst_r.bytes[0];
  assign is_esc    = burst_r.byte_valid && !esc_sent_r &&
                     (cur == ESC_BYTE || cur == CTLC_BYTE);
  assign is_last   = (burst_r.last_idx == 3'd0);
  assign finishing = step && !is_esc && is_last;
  assign can_load  = !burst_valid_r || finishing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_valid_r <= 1'b0;
      esc_sent_r    <= 1'b0;
    end else if (load) begin
      burst_valid_r <= 1'b1;
      esc_sent_r    <= 1'b0;
    end else if (finishing) begin
      burst_valid_r <= 1'b0;
      esc_sent_r    <= 1'b0;
    end else if (step) begin
      esc_sent_r <= is_esc;
    end
  end

  // burst payload: shift down one slot per finished byte
  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end else if (step && !is_esc && !is_last) begin
      burst_r.bytes    <= {8'h00, burst_r.bytes[BURST_LEN-1:1]};
      burst_r.last_idx <= burst_r.last_idx - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r   <= is_esc ? ESC_BYTE : cur;
      out_last_r   <= !is_esc && is_last;
      out_done_r   <= !is_esc && is_last && burst_r.done;
      out_bvalid_r <= burst_r.byte_valid;
      out_status_r <= burst_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_done_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bvalid_r;

endmodule

`default_nettype wire

// ===== sv/escaped_crc_frame_sender.sv =====
// Each result passes the burst register, then the output register, to out_*.
// Throughput: one line byte (or status result) per cycle while out_tready does not
// stall; an item causes 1 to 9 results, issued through the single output register.
// The next item is accepted in the cycle its predecessor's last byte is issued.
// Reset (rst_n low, synchronous): no frame open, CRC and count cleared,
// burst and output registers empty.
// ----------------------------------------------------------------------------
// escaped_crc_frame_sender: top level
// Byte-stuffed download frame sender with length header and CRC-16 trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_crc_frame_sender
  import ecfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] frame_length, [39:32] data_byte
  input  wire logic                  in_tuser,   // [0] mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] out_byte, [8] frame_done,
                                                 // [10:9] status, [15:11] zero
  output logic                       out_tlast,  // last_of_run
  output logic                       out_tuser   // [0] byte_valid
);

  logic   accept;
  logic   can_load;
  burst_t burst;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  ecfs_build u_build (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_tuser),
    .frame_length (in_tdata[31:0]),
    .data_byte    (in_tdata[39:32]),
    .burst        (burst)
  );

  ecfs_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .burst      (burst),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef NO_ASSERTIONS
  // frame close is always the last result of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tlast && out_tuser)
    else $error("frame_done without last_of_run");

  // error results carry no line byte and stand alone
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:9] != STAT_OK) |-> !out_tuser && out_tlast)
    else $error("error status on a line byte");

  // emitter is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: escaped CRC frame sender
// Drives header and data transfers with random gaps and output stalls and
// predicts every line byte, ESC prefix, CRC trailer byte and status result.
// A short table of directed items comes first, then random frames.
// ----------------------------------------------------------------------------

module testbench;
  import ecfs_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int DRAIN        = 16;
  localparam int RANDOM_ITEMS = 410;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 120;
  localparam int QUIET_LO     = 260;
  localparam int QUIET_HI     = 340;

  typedef struct {
    logic [7:0] octet;
    logic       valid;
    logic       last;
    logic       done;
    status_t    status;
  } line_rec_t;

  typedef struct {
    logic        mode;
    logic [31:0] len;
    logic [7:0]  data;
    logic        typed;         // expectation given in the row itself
    status_t     typed_status;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  escaped_crc_frame_sender dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] crc_acc       = 16'h0000;
  logic [31:0] left_count    = 32'h0;
  logic        frame_is_open = 1'b0;

  line_rec_t burst_q[$];   // lines caused by the item just accepted
  line_rec_t line_q[$];    // lines still to come from the block
  stim_row_t dir_rows[$];

  int items_sent    = 0;
  int lines_seen    = 0;
  int frames_closed = 0;
  int err_count     = 0;
  int cycle_count   = 0;
  bit held_off      = 1'b0;

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
    logic top;
    for (int k = 7; k >= 0; k--) begin
      top = c[15];
      c = {c[14:0], d[k]};
      if (top) begin
        c = c ^ 16'h1021;
      end
    end
    return c;
  endfunction

  function void emit_line(logic [7:0] b, logic v, logic d, status_t s);
    line_rec_t rec;
    rec.octet  = b;
    rec.valid  = v;
    rec.last   = 1'b0;
    rec.done   = d;
    rec.status = s;
    burst_q.push_back(rec);
  endfunction

  function void emit_escaped(logic [7:0] b, logic d);
    if (b == ESC_BYTE || b == CTLC_BYTE) begin
      emit_line(ESC_BYTE, 1'b1, 1'b0, STAT_OK);
    end
    emit_line(b, 1'b1, d, STAT_OK);
  endfunction

  function void predict_item(logic mode, logic [31:0] len, logic [7:0] data);
    burst_q.delete();
    if (mode == MODE_HEADER) begin
      if (len == 32'h0) begin
        emit_line(8'h00, 1'b0, 1'b0, STAT_ZERO_LEN);
      end else begin
        emit_line(START_MARK, 1'b1, 1'b0, STAT_OK);
        for (int i = 0; i < 4; i++) begin
          emit_escaped(len[8*i +: 8], 1'b0);
        end
        crc_acc       = 16'h0000;
        left_count    = len;
        frame_is_open = 1'b1;
      end
    end else if (!frame_is_open) begin
      emit_line(8'h00, 1'b0, 1'b0, STAT_NO_FRAME);
    end else begin
      emit_escaped(data, 1'b0);
      crc_acc    = crc_next(crc_acc, data);
      left_count = left_count - 32'h1;
      if (left_count == 32'h0) begin
        emit_escaped(crc_acc[7:0], 1'b0);
        emit_escaped(crc_acc[15:8], 1'b1);
        frame_is_open = 1'b0;
        frames_closed++;
      end
    end
  endfunction

  // unused field of each item gets random content
  function automatic stim_row_t mk_row(logic mode, logic [31:0] len, logic [7:0] data,
                                       logic typed = 1'b0, status_t st = STAT_OK);
    stim_row_t row;
    row.mode         = mode;
    row.len          = (mode == MODE_HEADER) ? len : 32'($urandom);
    row.data         = (mode == MODE_DATA) ? data : 8'($urandom);
    row.typed        = typed;
    row.typed_status = st;
    return row;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(11))
      0: b = ESC_BYTE;
      1: b = CTLC_BYTE;
      2: b = 8'h00;
      3: b = 8'hff;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic bit quiet_window();
    return items_sent >= QUIET_LO && items_sent < QUIET_HI;
  endfunction

  task automatic send_item(input stim_row_t row);
    line_rec_t rec;
    while (!quiet_window() && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.mode;
    in_tdata  <= {row.data, row.len};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_item(row.mode, row.len, row.data);
    if (row.typed) begin
      rec.octet  = 8'h00;
      rec.valid  = 1'b0;
      rec.last   = 1'b1;
      rec.done   = 1'b0;
      rec.status = row.typed_status;
      line_q.push_back(rec);
    end else begin
      for (int i = 0; i < burst_q.size(); i++) begin
        rec      = burst_q[i];
        rec.last = (i == burst_q.size() - 1);
        line_q.push_back(rec);
      end
    end
  endtask

  // sender
  initial begin
    int          pick;
    int          flen;
    int          cut;
    logic [31:0] rlen;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_HEADER;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'h5a, 1'b1, STAT_NO_FRAME));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h0, 8'h00, 1'b1, STAT_ZERO_LEN));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h1, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'h00));
    // two-byte frame: CRC comes out as 0x031b, both trailer bytes escaped
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h2, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, CTLC_BYTE));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, ESC_BYTE));
    // every length byte needs a prefix
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h1b031b03, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, ESC_BYTE));
    // zero length with a frame open leaves it open
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h0, 8'h00, 1'b1, STAT_ZERO_LEN));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'hff));
    // new header abandons the open frame
    dir_rows.push_back(mk_row(MODE_HEADER, 32'hffffffff, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'h80));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h3, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'h01));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'hfe));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'h7f));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, 8'hff, 1'b1, STAT_NO_FRAME));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h80000001, 8'h00));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h1, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, START_MARK));
    dir_rows.push_back(mk_row(MODE_HEADER, 32'h00000101, 8'h00));
    dir_rows.push_back(mk_row(MODE_DATA,   32'h0, CTLC_BYTE));

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i]);
    end

    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        // well-formed frame, now and then cut short
        flen = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
        cut  = ($urandom_range(9) == 0) ? $urandom_range(0, flen - 1) : flen;
        send_item(mk_row(MODE_HEADER, 32'(flen), 8'h00));
        for (int k = 0; k < cut; k++) begin
          send_item(mk_row(MODE_DATA, 32'h0, pick_byte()));
        end
      end else if (pick < 86) begin
        rlen = $urandom;
        send_item(mk_row(MODE_HEADER, rlen, 8'h00));
        repeat ($urandom_range(0, 3)) send_item(mk_row(MODE_DATA, 32'h0, pick_byte()));
      end else if (pick < 92) begin
        send_item(mk_row(MODE_HEADER, 32'h0, 8'h00));
      end else begin
        send_item(mk_row(MODE_DATA, 32'h0, pick_byte()));
      end
    end
    in_tvalid <= 1'b0;

    while (line_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("testbench: %0d items sent, %0d line results checked, %0d frames closed",
             items_sent, lines_seen, frames_closed);
    $display("testbench: %0d mismatches, %0d cycles", err_count, cycle_count);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stall-free stretch
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && items_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      out_tready <= quiet_window() ? 1'b1 : ($urandom_range(99) >= 15);
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    line_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      lines_seen++;
      if (line_q.size() == 0) begin
        $error("unexpected result transfer: out_byte %h", out_tdata[7:0]);
        err_count++;
      end else begin
        want = line_q.pop_front();
        if (out_tdata[7:0] !== want.octet) begin
          $error("out_byte: expected %h, got %h", want.octet, out_tdata[7:0]);
          err_count++;
        end
        if (out_tuser !== want.valid) begin
          $error("byte_valid: expected %b, got %b", want.valid, out_tuser);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_tlast);
          err_count++;
        end
        if (out_tdata[8] !== want.done) begin
          $error("frame_done: expected %b, got %b", want.done, out_tdata[8]);
          err_count++;
        end
        if (out_tdata[10:9] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[10:9]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("testbench: timeout after %0d cycles, %0d results pending",
               cycle_count, line_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/ecfs_pkg.sv
sv/ecfs_build.sv
sv/ecfs_emit.sv
sv/escaped_crc_frame_sender.sv
dv/testbench.sv
